>>> src/fdes_pkg.sv
`default_nettype none
package fdes_pkg;

  localparam int NAME_CHARS_DEF = 64;
  localparam int ENTRY_BYTES    = 32;
  localparam int POS_W          = $clog2(ENTRY_BYTES);
  localparam int IDX_W          = 16;
  localparam int CHAR_W         = 8;
  localparam int LONG_CHARS     = 13;
  localparam int SHORT_LEN      = 11;
  localparam int ATTR_OFS       = 11;
  localparam int DOT_POS        = 8;
  localparam int ATTR_VOL_BIT   = 3;
  localparam int CMD_DEPTH      = 2;
  localparam int LPOS_W         = 12;
  localparam int CI_W           = $clog2(LONG_CHARS);

  localparam logic [CHAR_W-1:0] MARK_END   = 8'h00;
  localparam logic [CHAR_W-1:0] MARK_DEL   = 8'he5;
  localparam logic [CHAR_W-1:0] MARK_KANJI = 8'h05;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] ATTR_LONG  = 8'h0f;
  localparam logic [CHAR_W-1:0] ORDER_LAST = 8'h40;

  // byte offsets of the 13 long-name characters, element 12 first (element 0 last)
  localparam logic [LONG_CHARS-1:0][POS_W-1:0] LONG_OFS = {
    5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
    5'd14, 5'd9,  5'd7,  5'd5,  5'd3,  5'd1
  };

  typedef enum logic [1:0] {
    CMD_END,
    CMD_LONG,
    CMD_SHORT
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LONG,
    ST_SHORT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_END_OUT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e                         kind;
    logic                              clr;
    logic [IDX_W-1:0]                  idx;
    logic [CHAR_W-1:0]                 order;
    logic [LONG_CHARS-1:0][CHAR_W-1:0] chars;
    logic                              vol;
  } cmd_t;

endpackage
`default_nettype wire

>>> src/fdes_front.sv
`default_nettype none
module fdes_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [fdes_pkg::CHAR_W-1:0]      entry_byte_i,
  input  wire                              dir_start_i,
  input  wire                              full_i,
  output logic                             push_o,
  output fdes_pkg::cmd_t                   cmd_o
);

  logic [fdes_pkg::CHAR_W-1:0] ent_q [fdes_pkg::ENTRY_BYTES];
  logic [fdes_pkg::POS_W-1:0]  pos_q, pos_d, pos_eff;
  logic [fdes_pkg::IDX_W-1:0]  cnt_q, cnt_d, cnt_eff;
  logic                        ended_q, ended_d, ended_eff;
  logic                        pclr_q, pclr_d, pclr_eff;
  logic                        acc, last_byte;
  logic [fdes_pkg::CHAR_W-1:0] b0, attr;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i && !full_i;
  assign pos_eff    = dir_start_i ? '0 : pos_q;
  assign cnt_eff    = dir_start_i ? '0 : cnt_q;
  assign ended_eff  = dir_start_i ? 1'b0 : ended_q;
  assign pclr_eff   = dir_start_i | pclr_q;
  assign last_byte  = (pos_eff == fdes_pkg::POS_W'(fdes_pkg::ENTRY_BYTES - 1));
  assign b0         = ent_q[0];
  assign attr       = ent_q[fdes_pkg::ATTR_OFS];

  always_comb begin
    cmd_o       = '0;
    cmd_o.idx   = cnt_eff;
    cmd_o.clr   = pclr_eff;
    cmd_o.order = b0 & ~fdes_pkg::ORDER_LAST;
    cmd_o.vol   = attr[fdes_pkg::ATTR_VOL_BIT];
    if (b0 == fdes_pkg::MARK_END) begin
      cmd_o.kind = fdes_pkg::CMD_END;
    end else if (attr == fdes_pkg::ATTR_LONG) begin
      cmd_o.kind = fdes_pkg::CMD_LONG;
      for (int i = 0; i < fdes_pkg::LONG_CHARS; i++) begin
        cmd_o.chars[i] = ent_q[fdes_pkg::LONG_OFS[i]];
      end
    end else begin
      cmd_o.kind = fdes_pkg::CMD_SHORT;
      for (int i = 0; i < fdes_pkg::SHORT_LEN; i++) begin
        cmd_o.chars[i] = ent_q[i];
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    ended_d = ended_q;
    pclr_d  = pclr_q;
    push_o  = 1'b0;
    if (acc) begin
      pos_d   = pos_eff;
      cnt_d   = cnt_eff;
      ended_d = ended_eff;
      pclr_d  = pclr_eff;
      if (!ended_eff) begin
        pos_d = fdes_pkg::POS_W'(pos_eff + 1'b1);
        if (last_byte) begin
          cnt_d  = fdes_pkg::IDX_W'(cnt_eff + 1'b1);
          push_o = (b0 != fdes_pkg::MARK_DEL);
          if (b0 == fdes_pkg::MARK_END) begin
            ended_d = 1'b1;
          end
          if (push_o) begin
            pclr_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cnt_q   <= '0;
      ended_q <= 1'b0;
      pclr_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      ended_q <= ended_d;
      pclr_q  <= pclr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !ended_eff) begin
      ent_q[pos_eff] <= entry_byte_i;
    end
  end

endmodule
`default_nettype wire

>>> src/fdes_cmd_fifo.sv
`default_nettype none
module fdes_cmd_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  fdes_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output fdes_pkg::cmd_t  cmd_o
);

  localparam int PW = (fdes_pkg::CMD_DEPTH > 1) ? $clog2(fdes_pkg::CMD_DEPTH) : 1;
  localparam int CW = $clog2(fdes_pkg::CMD_DEPTH + 1);

  fdes_pkg::cmd_t  buf_q [fdes_pkg::CMD_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(fdes_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = buf_q[rp_q];

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    if (p == PW'(fdes_pkg::CMD_DEPTH - 1)) begin
      return '0;
    end
    return PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= nxt(wp_q);
      end
      if (do_pop) begin
        rp_q <= nxt(rp_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

>>> src/fdes_back.sv
`default_nettype none
module fdes_back #(
  parameter int NAME_CHARS = fdes_pkg::NAME_CHARS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          empty_i,
  input  fdes_pkg::cmd_t               cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [fdes_pkg::CHAR_W-1:0]  name_char_o,
  output logic                         last_char_o,
  output logic [fdes_pkg::IDX_W-1:0]   entry_index_o,
  output logic                         dir_end_o
);

  localparam int AW = $clog2(NAME_CHARS);
  localparam int KW = $clog2(NAME_CHARS + 1);
  localparam int LW = fdes_pkg::LPOS_W;
  localparam int CW = fdes_pkg::CHAR_W;

  fdes_pkg::back_state_e state_q, state_d;
  fdes_pkg::cmd_t        cmd_q, cmd_d;

  logic [CW-1:0]          mem [NAME_CHARS];
  logic [NAME_CHARS-1:0]  vld_q, vld_d;
  logic [CW-1:0]          rdata_q;
  logic                   rdv_q;
  logic                   nz0_q, nz0_d, nz0_eff;
  logic [LW-1:0]          lpos_q, lpos_d, lbase, om1;
  logic [fdes_pkg::CI_W-1:0] li_q, li_d, si_q, si_d;
  logic [AW-1:0]          spos_q, spos_d;
  logic                   dot_q, dot_d;
  logic [KW-1:0]          nk_q, nk_d;
  logic                   pe_q, pe_d;
  logic [CW-1:0]          hold_q, hold_d;
  logic                   hh_q, hh_d;

  logic                   we, re, load, can_load;
  logic [AW-1:0]          waddr, raddr;
  logic [CW-1:0]          wdata, r, sch;
  logic                   o_last, o_end;
  logic [CW-1:0]          o_char;
  logic                   ov_q;

  assign can_load = !ov_q || !out_stall_i;
  assign nz0_eff  = cmd_i.clr ? 1'b0 : nz0_q;
  assign om1      = {{(LW - CW){1'b0}}, cmd_i.order} - LW'(1);
  assign lbase    = LW'(om1 * LW'(fdes_pkg::LONG_CHARS));
  assign r        = (pe_q || !rdv_q) ? '0 : rdata_q;
  assign sch      = cmd_q.chars[si_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdes_pkg::ST_IDLE: begin
        if (!empty_i) begin
          unique case (cmd_i.kind)
            fdes_pkg::CMD_END:  state_d = fdes_pkg::ST_END_OUT;
            fdes_pkg::CMD_LONG: begin
              state_d = (cmd_i.order == '0) ? fdes_pkg::ST_IDLE : fdes_pkg::ST_LONG;
            end
            fdes_pkg::CMD_SHORT: begin
              if (!nz0_eff) begin
                state_d = fdes_pkg::ST_SHORT;
              end else if (cmd_i.vol) begin
                state_d = fdes_pkg::ST_IDLE;
              end else begin
                state_d = fdes_pkg::ST_EMIT_RD;
              end
            end
            default: state_d = fdes_pkg::ST_IDLE;
          endcase
        end
      end
      fdes_pkg::ST_LONG: begin
        if (li_q == fdes_pkg::CI_W'(fdes_pkg::LONG_CHARS - 1)) begin
          state_d = fdes_pkg::ST_IDLE;
        end
      end
      fdes_pkg::ST_SHORT: begin
        if (si_q == fdes_pkg::CI_W'(fdes_pkg::SHORT_LEN - 1) &&
            !(sch != fdes_pkg::CHAR_SPACE &&
              si_q == fdes_pkg::CI_W'(fdes_pkg::DOT_POS) && !dot_q)) begin
          state_d = cmd_q.vol ? fdes_pkg::ST_IDLE : fdes_pkg::ST_EMIT_RD;
        end
      end
      fdes_pkg::ST_EMIT_RD: state_d = fdes_pkg::ST_EMIT;
      fdes_pkg::ST_EMIT: begin
        if (can_load && r == '0) begin
          state_d = fdes_pkg::ST_IDLE;
        end
      end
      fdes_pkg::ST_END_OUT: begin
        if (can_load) begin
          state_d = fdes_pkg::ST_IDLE;
        end
      end
      default: state_d = fdes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d  = cmd_q;
    vld_d  = vld_q;
    nz0_d  = nz0_q;
    lpos_d = lpos_q;
    li_d   = li_q;
    si_d   = si_q;
    spos_d = spos_q;
    dot_d  = dot_q;
    nk_d   = nk_q;
    pe_d   = pe_q;
    hold_d = hold_q;
    hh_d   = hh_q;
    pop_o  = 1'b0;
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    re     = 1'b0;
    raddr  = '0;
    load   = 1'b0;
    o_char = '0;
    o_last = 1'b0;
    o_end  = 1'b0;
    unique case (state_q)
      fdes_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = cmd_i;
          lpos_d = lbase;
          li_d   = '0;
          si_d   = '0;
          spos_d = '0;
          dot_d  = 1'b0;
          if (cmd_i.clr) begin
            vld_d = '0;
            nz0_d = 1'b0;
          end
        end
      end
      fdes_pkg::ST_LONG: begin
        if (lpos_q < LW'(NAME_CHARS)) begin
          we    = 1'b1;
          waddr = lpos_q[AW-1:0];
          wdata = cmd_q.chars[li_q];
        end
        lpos_d = LW'(lpos_q + 1'b1);
        li_d   = fdes_pkg::CI_W'(li_q + 1'b1);
      end
      fdes_pkg::ST_SHORT: begin
        if (sch == fdes_pkg::CHAR_SPACE) begin
          si_d = fdes_pkg::CI_W'(si_q + 1'b1);
        end else if (si_q == fdes_pkg::CI_W'(fdes_pkg::DOT_POS) && !dot_q) begin
          we     = 1'b1;
          waddr  = spos_q;
          wdata  = fdes_pkg::CHAR_DOT;
          spos_d = AW'(spos_q + 1'b1);
          dot_d  = 1'b1;
        end else begin
          we     = 1'b1;
          waddr  = spos_q;
          wdata  = (sch == fdes_pkg::MARK_KANJI) ? fdes_pkg::MARK_DEL : sch;
          spos_d = AW'(spos_q + 1'b1);
          si_d   = fdes_pkg::CI_W'(si_q + 1'b1);
        end
      end
      fdes_pkg::ST_EMIT_RD: begin
        re    = 1'b1;
        raddr = '0;
        nk_d  = KW'(1);
        pe_d  = 1'b0;
        hh_d  = 1'b0;
      end
      fdes_pkg::ST_EMIT: begin
        if (can_load) begin
          o_char = hold_q;
          if (r == '0) begin
            load   = 1'b1;
            o_char = hh_q ? hold_q : '0;
            o_last = 1'b1;
            vld_d  = '0;
            nz0_d  = 1'b0;
          end else begin
            load   = hh_q;
            hold_d = r;
            hh_d   = 1'b1;
            if (nk_q == KW'(NAME_CHARS)) begin
              pe_d = 1'b1;
            end else begin
              re    = 1'b1;
              raddr = nk_q[AW-1:0];
              nk_d  = KW'(nk_q + 1'b1);
            end
          end
        end
      end
      fdes_pkg::ST_END_OUT: begin
        if (can_load) begin
          load   = 1'b1;
          o_last = 1'b1;
          o_end  = 1'b1;
        end
      end
      default: ;
    endcase
    if (we) begin
      vld_d[waddr] = 1'b1;
      if (waddr == '0) begin
        nz0_d = (wdata != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdes_pkg::ST_IDLE;
      vld_q   <= '0;
      nz0_q   <= 1'b0;
      ov_q    <= 1'b0;
      li_q    <= '0;
      si_q    <= '0;
      dot_q   <= 1'b0;
      nk_q    <= '0;
      pe_q    <= 1'b0;
      hh_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      nz0_q   <= nz0_d;
      li_q    <= li_d;
      si_q    <= si_d;
      dot_q   <= dot_d;
      nk_q    <= nk_d;
      pe_q    <= pe_d;
      hh_q    <= hh_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    lpos_q <= lpos_d;
    spos_q <= spos_d;
    hold_q <= hold_d;
    if (load) begin
      name_char_o   <= o_char;
      last_char_o   <= o_last;
      entry_index_o <= cmd_q.idx;
      dir_end_o     <= o_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
      rdv_q   <= vld_q[raddr];
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

>>> src/fat_dir_entry_name_scanner_core.sv
// Takes one directory byte per cycle; a word is stalled only while the entry queue is full.
// A long-name entry holds the name builder while its characters are written (not when its order
// is 0), a short entry during name build plus one read step, then one name character per cycle
// while the output is not stalled.
// Reset clears control state and the name store valid bits at once; no clearing pass.
`default_nettype none
module fat_dir_entry_name_scanner_core #(
  parameter int NAME_CHARS = fdes_pkg::NAME_CHARS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [fdes_pkg::CHAR_W-1:0]  entry_byte_i,
  input  wire                          dir_start_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [fdes_pkg::CHAR_W-1:0]  name_char_o,
  output logic                         last_char_o,
  output logic [fdes_pkg::IDX_W-1:0]   entry_index_o,
  output logic                         dir_end_o
);

  fdes_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, full, empty;

  fdes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .entry_byte_i (entry_byte_i),
    .dir_start_i  (dir_start_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  fdes_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  fdes_back #(
    .NAME_CHARS (NAME_CHARS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .name_char_o   (name_char_o),
    .last_char_o   (last_char_o),
    .entry_index_o (entry_index_o),
    .dir_end_o     (dir_end_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/fat_dir_entry_name_scanner_core_test.sv
`timescale 1ns / 1ps
module fat_dir_entry_name_scanner_core_test;

  localparam int NAME_CHARS = fdes_pkg::NAME_CHARS_DEF;
  localparam int ATTR_AT = 11;
  localparam int LFN_CHARS = 13;
  localparam int SHORT_CHARS = 11;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [7:0] FREE_END = 8'h00;
  localparam logic [7:0] DELETED = 8'he5;
  localparam logic [7:0] KANJI = 8'h05;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] DOT = 8'h2e;
  localparam logic [7:0] ATTR_LFN = 8'h0f;
  localparam logic [7:0] ATTR_VOL = 8'h08;
  localparam logic [7:0] ORDER_LAST = 8'h40;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       hold;
  } dir_word_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [15:0] idx;
    logic        fin;
  } name_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [fdes_pkg::CHAR_W-1:0]   entry_byte = '0;
  logic                          dir_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [fdes_pkg::CHAR_W-1:0]   name_char;
  logic                          last_char;
  logic [fdes_pkg::IDX_W-1:0]    entry_index;
  logic                          dir_end;

  fat_dir_entry_name_scanner_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .entry_byte_i (entry_byte),
    .dir_start_i  (dir_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .name_char_o  (name_char),
    .last_char_o  (last_char),
    .entry_index_o(entry_index),
    .dir_end_o    (dir_end)
  );

  dir_word_t  word_q[$];
  name_char_t name_q[$];
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int quiet_cyc = 0;
  int run_cyc = 0;
  dir_word_t  nxt_word;
  logic       nxt_valid;
  name_char_t got_exp;

  // scanner state mirror
  logic [4:0]  scan_pos;
  logic [7:0]  scan_entry [32];
  logic [7:0]  scan_name [NAME_CHARS];
  logic [15:0] scan_count;
  logic        scan_done;

  // entry under construction
  logic [7:0] ent [32];
  logic       start_dir = 1'b0;
  logic       drain_next = 1'b0;

  function automatic int lfn_ofs(input int i);
    if (i < 5) return 1 + 2 * i;
    if (i < 11) return 14 + 2 * (i - 5);
    return 28 + 2 * (i - 11);
  endfunction

  function automatic bit may_idle();
    return word_q.size() >= 64 && run_cyc % 600 < 400;
  endfunction

  task automatic clear_scan();
    int i;
    scan_pos = '0;
    for (i = 0; i < 32; i++) scan_entry[i] = '0;
    for (i = 0; i < NAME_CHARS; i++) scan_name[i] = '0;
    scan_count = '0;
    scan_done = 1'b0;
  endtask

  task automatic emit_char(input logic [7:0] ch, input logic last, input logic [15:0] idx,
                           input logic fin);
    name_char_t r;
    r.ch = ch;
    r.last = last;
    r.idx = idx;
    r.fin = fin;
    name_q.push_back(r);
  endtask

  task automatic decode_scan(input logic [15:0] idx);
    logic [7:0] attr;
    logic [7:0] ch;
    logic [7:0] ord;
    int base;
    int p;
    int i;
    int len;
    attr = scan_entry[ATTR_AT];
    if (scan_entry[0] == FREE_END) begin
      scan_done = 1'b1;
      emit_char(8'h00, 1'b1, idx, 1'b1);
    end else if (scan_entry[0] != DELETED) begin
      if (attr == ATTR_LFN) begin
        ord = scan_entry[0] & ~ORDER_LAST;
        base = (int'(ord) - 1) * LFN_CHARS;
        for (i = 0; i < LFN_CHARS; i++) begin
          p = base + i;
          if (p >= 0 && p < NAME_CHARS) scan_name[p] = scan_entry[lfn_ofs(i)];
        end
      end else begin
        if (scan_name[0] == 8'h00) begin
          p = 0;
          for (i = 0; i < SHORT_CHARS; i++) begin
            ch = scan_entry[i];
            if (ch != SPACE) begin
              if (i == 8 && p < NAME_CHARS) begin
                scan_name[p] = DOT;
                p++;
              end
              if (ch == KANJI) ch = DELETED;
              if (p < NAME_CHARS) begin
                scan_name[p] = ch;
                p++;
              end
            end
          end
        end
        if ((attr & ATTR_VOL) == 8'h00) begin
          len = 0;
          while (len < NAME_CHARS && scan_name[len] != 8'h00) len++;
          if (len == 0) emit_char(8'h00, 1'b1, idx, 1'b0);
          for (i = 0; i < len; i++) emit_char(scan_name[i], i == len - 1, idx, 1'b0);
          for (i = 0; i < NAME_CHARS; i++) scan_name[i] = 8'h00;
        end
      end
    end
  endtask

  task automatic scan_word(input logic [7:0] b, input logic st);
    logic [15:0] idx;
    if (st) clear_scan();
    if (!scan_done) begin
      scan_entry[scan_pos] = b;
      scan_pos = scan_pos + 5'd1;
      if (scan_pos == 5'd0) begin
        idx = scan_count;
        scan_count = scan_count + 16'd1;
        decode_scan(idx);
      end
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic st, input logic hold);
    dir_word_t w;
    w.b = b;
    w.st = st;
    w.hold = hold;
    word_q.push_back(w);
  endtask

  task automatic push_entry();
    int i;
    for (i = 0; i < 32; i++) push_word(ent[i], start_dir && i == 0, drain_next && i == 0);
    start_dir = 1'b0;
    drain_next = 1'b0;
  endtask

  task automatic push_junk(input int n);
    int i;
    for (i = 0; i < n; i++) push_word(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic set_random();
    int i;
    for (i = 0; i < 32; i++) ent[i] = 8'($urandom);
  endtask

  task automatic set_short(input string nm, input logic [7:0] attr);
    int i;
    set_random();
    for (i = 0; i < SHORT_CHARS; i++) ent[i] = nm.getc(i);
    ent[ATTR_AT] = attr;
  endtask

  // nul < 0: all 13 characters used
  task automatic set_long(input logic [7:0] order, input int nul);
    int i;
    int o;
    set_random();
    ent[0] = order;
    ent[ATTR_AT] = ATTR_LFN;
    for (i = 0; i < LFN_CHARS; i++) begin
      o = lfn_ofs(i);
      if (nul >= 0 && i > nul) begin
        ent[o] = 8'hff;
        ent[o + 1] = 8'hff;
      end else if (i == nul) begin
        ent[o] = 8'h00;
        ent[o + 1] = 8'h00;
      end else begin
        ent[o] = 8'($urandom_range(1, 255));
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) scan_word(entry_byte, dir_start);
      if (!in_valid || !in_stall) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (may_idle() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 11);
        end else if (word_q.size() > 0 && !(word_q[0].hold && name_q.size() > 0)) begin
          nxt_word = word_q.pop_front();
          nxt_valid = 1'b1;
          entry_byte <= nxt_word.b;
          dir_start <= nxt_word.st;
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // result stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (may_idle() && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (name_q.size() == 0) begin
        $display("%0t: unexpected word: char %h last %b idx %0d end %b", $realtime,
                 name_char, last_char, entry_index, dir_end);
        errors++;
      end else begin
        got_exp = name_q.pop_front();
        if (name_char !== got_exp.ch) begin
          $display("%0t: name_char expected %h actual %h", $realtime, got_exp.ch, name_char);
          errors++;
        end
        if (last_char !== got_exp.last) begin
          $display("%0t: last_char expected %b actual %b", $realtime, got_exp.last, last_char);
          errors++;
        end
        if (entry_index !== got_exp.idx) begin
          $display("%0t: entry_index expected %0d actual %0d", $realtime, got_exp.idx,
                   entry_index);
          errors++;
        end
        if (dir_end !== got_exp.fin) begin
          $display("%0t: dir_end expected %b actual %b", $realtime, got_exp.fin, dir_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cyc++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int k;
    clear_scan();

    start_dir = 1'b1;
    set_short("XA B    T X", 8'h00);
    ent[0] = KANJI;
    push_entry();
    set_short("GONE    TXT", 8'h20);
    ent[0] = DELETED;
    push_entry();
    // full store, last part partly out of range
    for (k = 5; k >= 1; k--) begin
      set_long(k == 5 ? 8'h45 : 8'(k), -1);
      push_entry();
    end
    set_short("LONGNA~1   ", 8'h20);
    push_entry();
    drain_next = 1'b1;
    set_short("MYDISK     ", ATTR_VOL);
    push_entry();
    set_short("OTHER   DAT", 8'h20);
    push_entry();
    set_random();
    ent[0] = FREE_END;
    push_entry();
    push_junk(3);
    start_dir = 1'b1;
    set_short("           ", 8'h10);
    push_entry();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() > 0 || in_valid) @(posedge clk_i);
    while (name_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && name_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
